/* sv/pairwise_l1_distance_histogram_assert.svh */
// Assertion helpers used by pldh_back.
`ifndef PAIRWISE_L1_DISTANCE_HISTOGRAM_ASSERT_SVH
`define PAIRWISE_L1_DISTANCE_HISTOGRAM_ASSERT_SVH

// Same-cycle implication, off while in reset.
`define PLDH_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while in reset.
`define PLDH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/pldh_pkg.sv */
`default_nettype none
package pldh_pkg;

  localparam int FIELD_W     = 5;
  localparam int FIELD_COUNT = 20;
  localparam int WORD_W      = 50;
  localparam int GROUP_SIZE  = 4;
  localparam int GROUPS      = FIELD_COUNT / GROUP_SIZE;
  localparam int GROUP_SUM_W = 7;   // 4 * 31 fits
  localparam int SUM_W       = 10;  // 20 * 31 fits
  localparam int DIST_W      = 9;
  localparam int BINS        = 512;
  localparam int BIN_W       = $clog2(BINS);
  localparam int EXPERIMENTS = 4;
  localparam int EXP_W       = $clog2(EXPERIMENTS);
  localparam int COUNT_W     = 48;
  localparam int BANK_W      = 2 * COUNT_W;

  localparam int IN_TDATA_W  = 216;
  localparam int OUT_TDATA_W = 136;
  localparam int OUT_PAD_W   = OUT_TDATA_W - 4 * DIST_W - 2 * COUNT_W;

  // in_tdata field offsets
  localparam int IN_FL_LSB = 0;
  localparam int IN_FH_LSB = IN_FL_LSB + WORD_W;
  localparam int IN_SL_LSB = IN_FH_LSB + WORD_W;
  localparam int IN_SH_LSB = IN_SL_LSB + WORD_W;
  localparam int IN_SE_BIT = IN_SH_LSB + WORD_W;
  localparam int IN_RP_LSB = IN_SE_BIT + 1;
  localparam int IN_RD_LSB = IN_RP_LSB + EXP_W;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic {
    CMD_COMPARE = 1'b0,
    CMD_READ    = 1'b1
  } cmd_e_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK
  } back_state_t;

  typedef struct packed {
    cmd_e_t                              cmd;
    logic [EXPERIMENTS-1:0][DIST_W-1:0]  tap_dist;
    logic                                same_entity;
    logic [EXP_W-1:0]                    read_prefix;
    logic [BIN_W-1:0]                    read_distance;
  } item_t;

  typedef struct packed {
    logic clearing;
  } back_status_t;

  function automatic logic [DIST_W-1:0] sat_dist(input logic [SUM_W-1:0] s);
    return (s > SUM_W'(BINS - 1)) ? DIST_W'(BINS - 1) : s[DIST_W-1:0];
  endfunction

  function automatic logic [COUNT_W-1:0] bump_count(input logic [COUNT_W-1:0] c);
    return (&c) ? c : c + COUNT_W'(1);
  endfunction

endpackage
`default_nettype wire

/* sv/pairwise_l1_distance_histogram.sv */
// Pairwise L1 distance histogram.
// Input stream (in_*): one beat is a command. tuser=0 compares a record pair:
// the L1 distance over the first 4, 8, 16 and 20 fields is saturated to 511 and
// bumps one bin per experiment in the hit counters, and in the dup counters when
// same_entity is set. tuser=1 reads one bin (read_prefix, read_distance).
// Output stream (out_*): exactly one result beat per command; a compare returns
// the four distances with zero counts, a read returns the counts with zero
// distances. Counters saturate at 2^48-1.
// A command waits in the queue, is popped into work_r as its bins are read, and
// its result is registered in LOOK. The back end pops no new command until LOOK
// ends; the counters are read then written (one port pair per experiment bank).
// A 2-entry queue decouples the distance front end from the counter back end,
// so input beats keep landing while a result waits on out_tready.
// Reset: a clearing pass zeroes every counter bin; in_tready stays
// low until it finishes. A stalled receiver holds out_tdata steady and, once
// the queue fills, in_tready drops.
`default_nettype none
module pairwise_l1_distance_histogram (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // first_fields_low, first_fields_high, second_fields_low, second_fields_high,
  // same_entity, read_prefix, read_distance, 4 zero bits
  input  wire logic [pldh_pkg::IN_TDATA_W-1:0]   in_tdata,
  // command
  input  wire logic [0:0]                        in_tuser,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // distance_4, distance_8, distance_16, distance_20, hit_count, dup_count,
  // 4 zero bits
  output logic [pldh_pkg::OUT_TDATA_W-1:0]       out_tdata
);

  pldh_pkg::item_t        front_item;
  pldh_pkg::item_t        q_item;
  pldh_pkg::back_status_t back_status;
  logic                   q_in_ready;
  logic                   q_valid;
  logic                   pop;
  logic                   push;

  assign in_tready = q_in_ready && !back_status.clearing;
  assign push      = in_tvalid && in_tready;

  pldh_front u_front (
    .in_tdata (in_tdata),
    .in_tuser (in_tuser),
    .item     (front_item)
  );

  pldh_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (front_item),
    .in_ready  (q_in_ready),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_item    (q_item)
  );

  pldh_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .pop        (pop),
    .status     (back_status),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
`default_nettype wire

/* sv/pldh_front.sv */
`default_nettype none
module pldh_front (
  input  wire logic [pldh_pkg::IN_TDATA_W-1:0] in_tdata,
  input  wire logic [0:0]                      in_tuser,
  output pldh_pkg::item_t                      item
);

  logic [pldh_pkg::FIELD_COUNT-1:0][pldh_pkg::FIELD_W-1:0]     fa;
  logic [pldh_pkg::FIELD_COUNT-1:0][pldh_pkg::FIELD_W-1:0]     fb;
  logic [pldh_pkg::FIELD_COUNT-1:0][pldh_pkg::FIELD_W-1:0]     diff;
  logic [pldh_pkg::GROUPS-1:0][pldh_pkg::GROUP_SUM_W-1:0]      grp;
  logic [pldh_pkg::SUM_W-1:0] s4, s8, s16, s20;

  assign fa = {in_tdata[pldh_pkg::IN_FH_LSB +: pldh_pkg::WORD_W],
               in_tdata[pldh_pkg::IN_FL_LSB +: pldh_pkg::WORD_W]};
  assign fb = {in_tdata[pldh_pkg::IN_SH_LSB +: pldh_pkg::WORD_W],
               in_tdata[pldh_pkg::IN_SL_LSB +: pldh_pkg::WORD_W]};

  always_comb begin
    for (int i = 0; i < pldh_pkg::FIELD_COUNT; i++) begin
      diff[i] = (fa[i] > fb[i]) ? (fa[i] - fb[i]) : (fb[i] - fa[i]);
    end
    for (int g = 0; g < pldh_pkg::GROUPS; g++) begin
      grp[g] = pldh_pkg::GROUP_SUM_W'(diff[4*g])   + pldh_pkg::GROUP_SUM_W'(diff[4*g+1])
             + pldh_pkg::GROUP_SUM_W'(diff[4*g+2]) + pldh_pkg::GROUP_SUM_W'(diff[4*g+3]);
    end
  end

  // taps after fields 4, 8, 16, 20
  assign s4  = pldh_pkg::SUM_W'(grp[0]);
  assign s8  = s4 + pldh_pkg::SUM_W'(grp[1]);
  assign s16 = s8 + pldh_pkg::SUM_W'(grp[2]) + pldh_pkg::SUM_W'(grp[3]);
  assign s20 = s16 + pldh_pkg::SUM_W'(grp[4]);

  always_comb begin
    item.cmd           = pldh_pkg::cmd_e_t'(in_tuser[0]);
    item.tap_dist[0]   = pldh_pkg::sat_dist(s4);
    item.tap_dist[1]   = pldh_pkg::sat_dist(s8);
    item.tap_dist[2]   = pldh_pkg::sat_dist(s16);
    item.tap_dist[3]   = pldh_pkg::sat_dist(s20);
    item.same_entity   = in_tdata[pldh_pkg::IN_SE_BIT];
    item.read_prefix   = in_tdata[pldh_pkg::IN_RP_LSB +: pldh_pkg::EXP_W];
    item.read_distance = in_tdata[pldh_pkg::IN_RD_LSB +: pldh_pkg::BIN_W];
  end

endmodule
`default_nettype wire

/* sv/pldh_queue.sv */
`default_nettype none
module pldh_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire pldh_pkg::item_t push_item,
  output logic                 in_ready,
  input  wire logic            pop,
  output logic                 q_valid,
  output pldh_pkg::item_t      q_item
);

  pldh_pkg::item_t              q_mem [pldh_pkg::QUEUE_DEPTH];
  logic [pldh_pkg::QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [pldh_pkg::QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [pldh_pkg::QCNT_W-1:0]  count_r, count_nxt;

  assign in_ready = (count_r != pldh_pkg::QCNT_W'(pldh_pkg::QUEUE_DEPTH));
  assign q_valid  = (count_r != '0);
  assign q_item   = q_mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + pldh_pkg::QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + pldh_pkg::QPTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + pldh_pkg::QCNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - pldh_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= push_item;
    end
  end

endmodule
`default_nettype wire

/* sv/pldh_back.sv */
`default_nettype none
`include "pairwise_l1_distance_histogram_assert.svh"
module pldh_back (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              q_valid,
  input  wire pldh_pkg::item_t                   q_item,
  output logic                                   pop,
  output pldh_pkg::back_status_t                 status,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [pldh_pkg::OUT_TDATA_W-1:0]       out_tdata
);

  pldh_pkg::back_state_t                 state_r, state_nxt;
  logic [pldh_pkg::BIN_W-1:0]            clr_addr_r, clr_addr_nxt;
  pldh_pkg::item_t                       work_r;
  logic [pldh_pkg::BANK_W-1:0]           rdata_r [pldh_pkg::EXPERIMENTS];
  logic                                  out_valid_r, out_valid_nxt;
  logic [pldh_pkg::OUT_TDATA_W-1:0]      out_data_r, out_data_nxt;

  logic                                  we;
  logic [pldh_pkg::BIN_W-1:0]            wr_addr [pldh_pkg::EXPERIMENTS];
  logic [pldh_pkg::BANK_W-1:0]           wr_data [pldh_pkg::EXPERIMENTS];
  logic [pldh_pkg::BIN_W-1:0]            rd_addr [pldh_pkg::EXPERIMENTS];
  logic [pldh_pkg::BANK_W-1:0]           sel_bank;

  assign out_tvalid      = out_valid_r;
  assign out_tdata       = out_data_r;
  assign status.clearing = (state_r == pldh_pkg::ST_CLEAR);
  assign sel_bank        = rdata_r[work_r.read_prefix];

  always_comb begin
    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    pop           = 1'b0;
    we            = 1'b0;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    for (int k = 0; k < pldh_pkg::EXPERIMENTS; k++) begin
      rd_addr[k] = (q_item.cmd == pldh_pkg::CMD_READ) ? q_item.read_distance
                                                      : q_item.tap_dist[k];
      wr_addr[k] = work_r.tap_dist[k];
      wr_data[k] = {pldh_pkg::bump_count(rdata_r[k][pldh_pkg::BANK_W-1 -: pldh_pkg::COUNT_W]),
                    work_r.same_entity
                      ? pldh_pkg::bump_count(rdata_r[k][pldh_pkg::COUNT_W-1:0])
                      : rdata_r[k][pldh_pkg::COUNT_W-1:0]};
    end
    unique case (state_r)
      pldh_pkg::ST_CLEAR: begin
        we = 1'b1;
        for (int k = 0; k < pldh_pkg::EXPERIMENTS; k++) begin
          wr_addr[k] = clr_addr_r;
          wr_data[k] = '0;
        end
        clr_addr_nxt = clr_addr_r + pldh_pkg::BIN_W'(1);
        if (clr_addr_r == pldh_pkg::BIN_W'(pldh_pkg::BINS - 1)) begin
          state_nxt = pldh_pkg::ST_IDLE;
        end
      end
      pldh_pkg::ST_IDLE: begin
        // output slot is free by the time the item reaches LOOK
        if (q_valid && (!out_valid_r || out_tready)) begin
          pop       = 1'b1;
          state_nxt = pldh_pkg::ST_LOOK;
        end
      end
      pldh_pkg::ST_LOOK: begin
        we            = (work_r.cmd == pldh_pkg::CMD_COMPARE);
        out_valid_nxt = 1'b1;
        if (work_r.cmd == pldh_pkg::CMD_READ) begin
          out_data_nxt = {{pldh_pkg::OUT_PAD_W{1'b0}},
                          sel_bank[pldh_pkg::COUNT_W-1:0],
                          sel_bank[pldh_pkg::BANK_W-1 -: pldh_pkg::COUNT_W],
                          {(4 * pldh_pkg::DIST_W){1'b0}}};
        end else begin
          out_data_nxt = {{pldh_pkg::OUT_PAD_W{1'b0}},
                          {(2 * pldh_pkg::COUNT_W){1'b0}},
                          work_r.tap_dist[3], work_r.tap_dist[2],
                          work_r.tap_dist[1], work_r.tap_dist[0]};
        end
        state_nxt = pldh_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = pldh_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pldh_pkg::ST_CLEAR;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    if (pop) begin
      work_r <= q_item;
    end
  end

  // one counter bank per experiment, {hit, dup} per bin
  for (genvar k = 0; k < pldh_pkg::EXPERIMENTS; k++) begin : g_bank
    logic [pldh_pkg::BANK_W-1:0] mem [pldh_pkg::BINS];
    always_ff @(posedge clk) begin
      if (we) begin
        mem[wr_addr[k]] <= wr_data[k];
      end
      if (pop) begin
        rdata_r[k] <= mem[rd_addr[k]];
      end
    end
  end

  `PLDH_ASSERT_NOW(a_no_pop_in_clear, clk, rst_n, state_r == pldh_pkg::ST_CLEAR, !pop, "item popped during clear")
  `PLDH_ASSERT_NEXT(a_look_once, clk, rst_n, state_r == pldh_pkg::ST_LOOK, state_r == pldh_pkg::ST_IDLE, "LOOK not followed by IDLE")
  `PLDH_ASSERT_NEXT(a_out_from_look, clk, rst_n, !out_valid_r && state_r != pldh_pkg::ST_LOOK, !out_valid_r, "result without a look cycle")
  `PLDH_ASSERT_NOW(a_look_slot_free, clk, rst_n, state_r == pldh_pkg::ST_LOOK, !out_valid_r, "result slot busy in LOOK")

endmodule
`default_nettype wire
